// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the pulse beat detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PBD_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PBD_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pbd_pkg.sv -----
// Package with the shared types and constants of the pulse beat detector.
package pbd_pkg;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned DEF_TAPS = 15;
	localparam int unsigned DEF_SLOTS = 8;
	localparam int unsigned INT_W = 11;
	localparam int unsigned BPM_W = 8;
	localparam int unsigned Q4_W = 12;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned NAVG_W = 4;
	localparam int unsigned PERIOD_W = 4;
	localparam int unsigned EVERY_W = 4;
	localparam int unsigned BSR_W = 4;
	localparam int unsigned JUMP_W = 8;
	localparam int unsigned ADAPT_W = 10;
	localparam int unsigned CFG_W = 11;
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned DIV_NW = 26;
	localparam int unsigned DIV_DW = 17;
	localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned OUT_TDATA_W = 56;
	localparam int unsigned OUT_TUSER_W = 3;

	localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 10'd550;
	localparam logic [SAMPLE_W-1:0] RST_LEVEL = 10'd512;
	localparam logic [INT_W-1:0] RST_REFRACTORY = 11'd250;
	localparam logic [INT_W-1:0] RST_MAX_INTERVAL = 11'd2000;
	localparam logic [PERIOD_W-1:0] RST_PERIOD = 4'd2;
	localparam logic [EVERY_W-1:0] RST_EVERY = 4'd2;
	localparam logic [JUMP_W-1:0] RST_JUMP = 8'd30;
	localparam logic [ADAPT_W-1:0] RST_ADAPT = 10'd100;

	localparam logic [CFG_AW-1:0] REG_INIT_THRESHOLD = 3'd0;
	localparam logic [CFG_AW-1:0] REG_REFRACTORY = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MAX_INTERVAL = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [CFG_AW-1:0] REG_REPORT_EVERY = 3'd4;
	localparam logic [CFG_AW-1:0] REG_MAX_JUMP = 3'd5;
	localparam logic [CFG_AW-1:0] REG_ADAPT_PERIOD = 3'd6;

	// Rate constants: 60000 ms per minute, and the same in Q4.
	localparam logic [DIV_NW-1:0] MS_PER_MIN = 26'd60000;
	localparam logic [DIV_NW-1:0] MS_PER_MIN_Q4 = 26'd960000;
	localparam logic [Q4_W-1:0] Q4_CAP = 12'd4095;
	localparam logic [BPM_W-1:0] BPM_CAP = 8'd255;

	// floor(v / 5) as (v * DIV5_MUL) >> DIV5_SHIFT, exact for v below 2**18.
	localparam int unsigned DIV5_SHIFT = 24;
	localparam logic [22:0] DIV5_MUL = 23'd3355444;

	typedef enum logic [1:0] {
		RPT_NONE = 2'd0,
		RPT_RATE = 2'd1,
		RPT_DETECT = 2'd2
	} report_t;

	typedef enum logic [1:0] {
		DSEL_FILT,
		DSEL_Q4,
		DSEL_INST,
		DSEL_AVG
	} div_sel_t;

	typedef struct packed {
		logic load;
		logic div_start;
		div_sel_t div_sel;
		logic upd;
		logic adapt;
		logic rep;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_q4;
		logic rep_ok;
		logic out_busy;
	} stat_t;
endpackage

// ----- design/pbd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module pbd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [pbd_pkg::DIV_NW-1:0] num,
	input logic [pbd_pkg::DIV_DW-1:0] den,
	output logic [pbd_pkg::DIV_NW-1:0] quot,
	output logic done
);
	import pbd_pkg::*;

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DW:0] trial;
	logic ge;
	logic [DIV_DW:0] diff;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], ge};
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign quot = num_q;
	assign done = done_q;
endmodule

// ----- design/pbd_dp.sv -----
// Datapath of the pulse beat detector: filter, beat logic, rate math and output register.
module pbd_dp #(
	parameter int unsigned TAPS = pbd_pkg::DEF_TAPS,
	parameter int unsigned SLOTS = pbd_pkg::DEF_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input pbd_pkg::cmd_t cmd,
	output pbd_pkg::stat_t stat,
	input logic cfg_we,
	input logic [pbd_pkg::CFG_AW-1:0] cfg_addr,
	input logic [pbd_pkg::CFG_W-1:0] cfg_data,
	input logic [pbd_pkg::SAMPLE_W-1:0] raw_sample,
	input logic out_ready,
	output logic out_valid,
	output logic [pbd_pkg::SAMPLE_W-1:0] filtered_sample,
	output logic beat,
	output logic [1:0] report,
	output logic [pbd_pkg::INT_W-1:0] interval_ms,
	output logic [pbd_pkg::BPM_W-1:0] instant_bpm,
	output logic [pbd_pkg::BPM_W-1:0] average_bpm,
	output logic [pbd_pkg::NAVG_W-1:0] intervals_averaged,
	output logic [pbd_pkg::SAMPLE_W-1:0] live_threshold
);
	import pbd_pkg::*;

	localparam int unsigned WSW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int unsigned WFW = $clog2(TAPS + 1);
	localparam int unsigned WTW = SAMPLE_W + WFW;
	localparam int unsigned ISW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned IFW = $clog2(SLOTS + 1);
	localparam int unsigned ITW = INT_W + IFW;

	// Configuration registers.
	logic [INT_W-1:0] refractory_q;
	logic [INT_W-1:0] max_int_q;
	logic [PERIOD_W-1:0] period_q;
	logic [EVERY_W-1:0] every_q;
	logic [JUMP_W-1:0] jump_q;
	logic [ADAPT_W-1:0] adapt_per_q;

	// Moving-average window.
	logic [SAMPLE_W-1:0] window_q [TAPS];
	logic [WSW-1:0] wslot_q;
	logic [WFW-1:0] wfill_q;
	logic [WTW-1:0] wtotal_q;

	// Beat tracking.
	logic [SAMPLE_W-1:0] sig_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [SAMPLE_W-1:0] trough_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic in_pulse_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [ADAPT_W-1:0] adapt_cnt_q;

	// Interval average.
	logic [INT_W-1:0] istore_q [SLOTS];
	logic [ISW-1:0] islot_q;
	logic [IFW-1:0] ifill_q;
	logic [ITW-1:0] itotal_q;
	logic [BSR_W-1:0] bsr_q;
	logic [Q4_W-1:0] last_q4_q;
	logic last_valid_q;

	// Per-item results.
	logic beat_q;
	logic need_q4_q;
	logic [INT_W-1:0] int_q;
	report_t report_q;
	logic [BPM_W-1:0] inst_q;
	logic [BPM_W-1:0] avg_q;
	logic [NAVG_W-1:0] navg_q;

	// Output register.
	logic out_valid_q;
	logic [SAMPLE_W-1:0] o_filt_q;
	logic o_beat_q;
	logic [1:0] o_report_q;
	logic [INT_W-1:0] o_int_q;
	logic [BPM_W-1:0] o_inst_q;
	logic [BPM_W-1:0] o_avg_q;
	logic [NAVG_W-1:0] o_navg_q;
	logic [SAMPLE_W-1:0] o_thr_q;

	logic div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_NW-1:0] div_quot;
	logic div_done;

	logic [WTW-1:0] wtotal_new;
	logic [WFW-1:0] wfill_new;
	logic [SAMPLE_W-1:0] sig;
	logic [ELAPSED_W:0] e_sum;
	logic [ELAPSED_W-1:0] e_new;
	logic beat_c;
	logic record_c;
	logic [BSR_W-1:0] bsr_inc;
	logic due_c;
	logic [ITW-1:0] itotal_base;
	logic [ADAPT_W-1:0] adapt_inc;
	logic [SAMPLE_W+1:0] span3;
	logic [SAMPLE_W+1+23:0] span_prod;
	logic [SAMPLE_W-1:0] span_fifth;
	logic [Q4_W-1:0] q4;
	logic [Q4_W-1:0] q4_diff;
	logic jump_c;
	logic [BPM_W-1:0] bpm_sat;

	assign wtotal_new = wtotal_q - WTW'(window_q[wslot_q]) + WTW'(raw_sample);
	assign wfill_new = (wfill_q < WFW'(TAPS)) ? wfill_q + 1'b1 : wfill_q;

	assign sig = div_quot[SAMPLE_W-1:0];
	assign e_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(period_q);
	assign e_new = e_sum[ELAPSED_W] ? '1 : e_sum[ELAPSED_W-1:0];
	assign beat_c = (sig > thr_q) && !in_pulse_q && (e_new > ELAPSED_W'(refractory_q));
	assign record_c = e_new < ELAPSED_W'(max_int_q);
	assign bsr_inc = bsr_q + 1'b1;
	assign due_c = bsr_inc >= every_q;
	assign itotal_base = (ifill_q >= IFW'(SLOTS)) ? itotal_q - ITW'(istore_q[islot_q])
		: itotal_q;

	assign adapt_inc = adapt_cnt_q + 1'b1;
	assign span3 = (SAMPLE_W + 2)'(peak_q - trough_q) * (SAMPLE_W + 2)'(3);
	assign span_prod = (SAMPLE_W + 25)'(span3) * (SAMPLE_W + 25)'(DIV5_MUL);
	assign span_fifth = span_prod[DIV5_SHIFT +: SAMPLE_W];

	assign q4 = (div_quot > DIV_NW'(Q4_CAP)) ? Q4_CAP : div_quot[Q4_W-1:0];
	assign q4_diff = (q4 > last_q4_q) ? q4 - last_q4_q : last_q4_q - q4;
	assign jump_c = last_valid_q && (q4_diff > {jump_q, 4'b0000});
	assign bpm_sat = (div_quot > DIV_NW'(BPM_CAP)) ? BPM_CAP : div_quot[BPM_W-1:0];

	always_comb begin
		div_start = cmd.div_start;
		case (cmd.div_sel)
			DSEL_FILT: begin
				div_num = DIV_NW'(wtotal_q);
				div_den = DIV_DW'(wfill_q);
			end
			DSEL_Q4: begin
				div_num = MS_PER_MIN_Q4 * DIV_NW'(ifill_q) + DIV_NW'(itotal_q >> 1);
				div_den = DIV_DW'(itotal_q);
			end
			DSEL_INST: begin
				div_num = MS_PER_MIN + DIV_NW'(int_q >> 1);
				div_den = DIV_DW'(int_q);
			end
			DSEL_AVG: begin
				div_num = MS_PER_MIN * DIV_NW'(ifill_q) + DIV_NW'(itotal_q >> 1);
				div_den = DIV_DW'(itotal_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	pbd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quot(div_quot),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refractory_q <= RST_REFRACTORY;
			max_int_q <= RST_MAX_INTERVAL;
			period_q <= RST_PERIOD;
			every_q <= RST_EVERY;
			jump_q <= RST_JUMP;
			adapt_per_q <= RST_ADAPT;
			for (int i = 0; i < TAPS; i++) window_q[i] <= '0;
			wslot_q <= '0;
			wfill_q <= '0;
			wtotal_q <= '0;
			peak_q <= RST_LEVEL;
			trough_q <= RST_LEVEL;
			thr_q <= RST_THRESHOLD;
			in_pulse_q <= 1'b0;
			elapsed_q <= '0;
			adapt_cnt_q <= '0;
			islot_q <= '0;
			ifill_q <= '0;
			itotal_q <= '0;
			bsr_q <= '0;
			last_q4_q <= '0;
			last_valid_q <= 1'b0;
			need_q4_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_INIT_THRESHOLD: thr_q <= cfg_data[SAMPLE_W-1:0];
					REG_REFRACTORY: refractory_q <= cfg_data[INT_W-1:0];
					REG_MAX_INTERVAL: max_int_q <= cfg_data[INT_W-1:0];
					REG_SAMPLE_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
					REG_REPORT_EVERY: every_q <= cfg_data[EVERY_W-1:0];
					REG_MAX_JUMP: jump_q <= cfg_data[JUMP_W-1:0];
					REG_ADAPT_PERIOD: adapt_per_q <= cfg_data[ADAPT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				window_q[wslot_q] <= raw_sample;
				wtotal_q <= wtotal_new;
				wfill_q <= wfill_new;
				wslot_q <= (wslot_q == WSW'(TAPS - 1)) ? '0 : wslot_q + 1'b1;
			end
			if (cmd.upd) begin
				need_q4_q <= beat_c && record_c && due_c;
				if (beat_c) begin
					in_pulse_q <= 1'b1;
					elapsed_q <= '0;
					peak_q <= sig;
					trough_q <= sig;
					if (record_c) begin
						itotal_q <= itotal_base + ITW'(e_new);
						islot_q <= (islot_q == ISW'(SLOTS - 1)) ? '0 : islot_q + 1'b1;
						if (ifill_q < IFW'(SLOTS)) ifill_q <= ifill_q + 1'b1;
						bsr_q <= due_c ? '0 : bsr_inc;
					end
				end else begin
					if (sig < thr_q) in_pulse_q <= 1'b0;
					elapsed_q <= e_new;
					if (sig > peak_q) peak_q <= sig;
					if (sig < trough_q) trough_q <= sig;
				end
			end
			if (cmd.adapt) begin
				if (adapt_inc >= adapt_per_q) begin
					adapt_cnt_q <= '0;
					if (peak_q > trough_q) thr_q <= trough_q + span_fifth;
				end else begin
					adapt_cnt_q <= adapt_inc;
				end
			end
			if (cmd.rep) begin
				last_q4_q <= q4;
				last_valid_q <= 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && beat_c && record_c) istore_q[islot_q] <= e_new[INT_W-1:0];
		if (cmd.upd) begin
			sig_q <= sig;
			beat_q <= beat_c;
			int_q <= e_new[INT_W-1:0];
			report_q <= RPT_NONE;
			inst_q <= '0;
			avg_q <= '0;
			navg_q <= '0;
		end
		if (cmd.rep) begin
			report_q <= jump_c ? RPT_DETECT : RPT_RATE;
			if (!jump_c) navg_q <= NAVG_W'(ifill_q);
		end
		if (div_done && cmd.div_sel == DSEL_INST) inst_q <= bpm_sat;
		if (div_done && cmd.div_sel == DSEL_AVG) avg_q <= bpm_sat;
		if (cmd.out_load) begin
			o_filt_q <= sig_q;
			o_beat_q <= beat_q;
			o_report_q <= report_q;
			o_int_q <= (report_q == RPT_RATE) ? int_q : '0;
			o_inst_q <= inst_q;
			o_avg_q <= avg_q;
			o_navg_q <= navg_q;
			o_thr_q <= thr_q;
		end
	end

	assign stat.div_done = div_done;
	assign stat.need_q4 = need_q4_q;
	assign stat.rep_ok = !jump_c;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign filtered_sample = o_filt_q;
	assign beat = o_beat_q;
	assign report = o_report_q;
	assign interval_ms = o_int_q;
	assign instant_bpm = o_inst_q;
	assign average_bpm = o_avg_q;
	assign intervals_averaged = o_navg_q;
	assign live_threshold = o_thr_q;
endmodule

// ----- design/pbd_ctrl.sv -----
// Controller state machine that sequences one sample through the datapath.
module pbd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pbd_pkg::stat_t stat,
	output pbd_pkg::cmd_t cmd
);
	import pbd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FSTART,
		ST_FWAIT,
		ST_UPD,
		ST_ADAPT,
		ST_QSTART,
		ST_QWAIT,
		ST_REP,
		ST_ISTART,
		ST_IWAIT,
		ST_ASTART,
		ST_AWAIT,
		ST_DONE
	} state_t;

	state_t state_q;
	div_sel_t sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= DSEL_FILT;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_FSTART;
				ST_FSTART: begin
					sel_q <= DSEL_FILT;
					state_q <= ST_FWAIT;
				end
				ST_FWAIT: if (stat.div_done) state_q <= ST_UPD;
				ST_UPD: state_q <= ST_ADAPT;
				ST_ADAPT: state_q <= stat.need_q4 ? ST_QSTART : ST_DONE;
				ST_QSTART: begin
					sel_q <= DSEL_Q4;
					state_q <= ST_QWAIT;
				end
				ST_QWAIT: if (stat.div_done) state_q <= ST_REP;
				ST_REP: state_q <= stat.rep_ok ? ST_ISTART : ST_DONE;
				ST_ISTART: begin
					sel_q <= DSEL_INST;
					state_q <= ST_IWAIT;
				end
				ST_IWAIT: if (stat.div_done) state_q <= ST_ASTART;
				ST_ASTART: begin
					sel_q <= DSEL_AVG;
					state_q <= ST_AWAIT;
				end
				ST_AWAIT: if (stat.div_done) state_q <= ST_DONE;
				ST_DONE: if (!stat.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_ready && in_valid;
		cmd.upd = (state_q == ST_UPD);
		cmd.adapt = (state_q == ST_ADAPT);
		cmd.rep = (state_q == ST_REP);
		cmd.out_load = (state_q == ST_DONE) && !stat.out_busy;
		cmd.div_start = (state_q == ST_FSTART) || (state_q == ST_QSTART)
			|| (state_q == ST_ISTART) || (state_q == ST_ASTART);
		case (state_q)
			ST_FSTART: cmd.div_sel = DSEL_FILT;
			ST_QSTART: cmd.div_sel = DSEL_Q4;
			ST_ISTART: cmd.div_sel = DSEL_INST;
			ST_ASTART: cmd.div_sel = DSEL_AVG;
			default: cmd.div_sel = sel_q;
		endcase
	end
endmodule

// ----- design/pulse_beat_detector_top.sv -----
// Top level of the pulse beat detector: stream ports, configuration port and packing.
//
// Samples enter on the s_ stream, one converter sample per transfer in s_tdata.
// Every sample gives exactly one result transfer on the m_ stream: the smoothed
// sample, the beat flag, the report kind and, with a rate report, the interval,
// instant and average BPM and the number of averaged intervals.
// When no report is due, a serial divide forms the moving average, followed
// by beat, threshold and output steps. A sample that is due a report runs one
// more divide of the same shared divider for the Q4 rate, and two more for
// instant and average BPM when it ends in a rate report.
// A finished result sits in the output register; the next sample is accepted
// while it waits, and the block holds at its last step if m_tready stays low.
// Reset clears the window, levels, counters and configuration to their defaults
// at once; no clearing pass is needed. Configuration is written through cfg_we,
// cfg_addr and cfg_data by the user only while idle; the block does not enforce it.
module pulse_beat_detector_top #(
	parameter int unsigned FILTER_TAPS = pbd_pkg::DEF_TAPS,
	parameter int unsigned INTERVAL_SLOTS = pbd_pkg::DEF_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// raw_sample [9:0], zero padding above.
	input logic [pbd_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// filtered_sample, interval_ms, instant_bpm, average_bpm, intervals_averaged,
	// live_threshold, zero padding above.
	output logic [pbd_pkg::OUT_TDATA_W-1:0] m_tdata,
	// beat, report.
	output logic [pbd_pkg::OUT_TUSER_W-1:0] m_tuser,
	input logic cfg_we,
	input logic [pbd_pkg::CFG_AW-1:0] cfg_addr,
	input logic [pbd_pkg::CFG_W-1:0] cfg_data
);
	import pbd_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic [SAMPLE_W-1:0] filtered_sample;
	logic beat;
	logic [1:0] report;
	logic [INT_W-1:0] interval_ms;
	logic [BPM_W-1:0] instant_bpm;
	logic [BPM_W-1:0] average_bpm;
	logic [NAVG_W-1:0] intervals_averaged;
	logic [SAMPLE_W-1:0] live_threshold;

	pbd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	pbd_dp #(
		.TAPS(FILTER_TAPS),
		.SLOTS(INTERVAL_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.raw_sample(s_tdata[SAMPLE_W-1:0]),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.filtered_sample(filtered_sample),
		.beat(beat),
		.report(report),
		.interval_ms(interval_ms),
		.instant_bpm(instant_bpm),
		.average_bpm(average_bpm),
		.intervals_averaged(intervals_averaged),
		.live_threshold(live_threshold)
	);

	assign m_tdata = {5'b00000, live_threshold, intervals_averaged, average_bpm,
		instant_bpm, interval_ms, filtered_sample};
	assign m_tuser = {report, beat};
endmodule

// ----- design/pbd_checker.sv -----
// Port-level checker of the pulse beat detector, bound to the top level.
`include "assert_macros.svh"

module pbd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0] m_tuser
);
	import pbd_pkg::*;

	`PBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid,
		"Result dropped while stalled.")
	`PBD_ASSERT_NOW(a_report_code, m_tvalid, m_tuser[2:1] <= RPT_DETECT,
		"Undefined report code.")
	`PBD_ASSERT_NOW(a_report_needs_beat, m_tvalid && m_tuser[2:1] != RPT_NONE, m_tuser[0],
		"Report without a beat.")
	`PBD_ASSERT_NOW(a_fields_zero, m_tvalid && m_tuser[2:1] != RPT_RATE,
		m_tdata[40:10] == 31'd0, "Rate fields set without a rate report.")
	`PBD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
		"Second sample taken while one is in work.")
endmodule

bind pulse_beat_detector_top pbd_checker u_pbd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
